>>> design/tcvt_pkg.sv
package tcvt_pkg;

	localparam int KEY_W             = 5;
	localparam int TICK_W            = 8;
	localparam int CONTACT_W         = 64;
	localparam int NUM_KEYS_DEF      = 29;
	localparam int FIRST_KEY_BIT_DEF = 6;

	// stream widths, padded to whole bytes
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 16;
	localparam int M_PAD_W   = M_TDATA_W - KEY_W - TICK_W;

	typedef enum logic {
		KIND_PRESS   = 1'b0,
		KIND_RELEASE = 1'b1
	} ev_kind_t;

	// what one key lane reports for the scan on its inputs
	typedef struct packed {
		logic              hit;
		ev_kind_t          kind;
		logic [TICK_W-1:0] elapsed;
	} lane_ev_t;

endpackage

>>> design/tcvt_lane.sv
module tcvt_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           upper,
	input  logic                           lower,
	input  logic [tcvt_pkg::TICK_W-1:0]    now_tick,
	output tcvt_pkg::lane_ev_t             ev
);

	typedef enum logic [3:0] {
		PH_RELEASED  = 4'b0001,
		PH_PRESSING  = 4'b0010,
		PH_PRESSED   = 4'b0100,
		PH_RELEASING = 4'b1000
	} phase_t;

	phase_t                        phase_q;
	phase_t                        phase_nxt;
	logic [tcvt_pkg::TICK_W-1:0]   start_q;
	logic                          store;

	always_comb begin
		phase_nxt  = phase_q;
		store      = 1'b0;
		ev.hit     = 1'b0;
		ev.kind    = tcvt_pkg::KIND_PRESS;
		ev.elapsed = now_tick - start_q;
		case (phase_q)
			PH_RELEASED: begin
				if (lower && !upper) begin
					phase_nxt = PH_PRESSING;
					store     = 1'b1;
				end
			end
			PH_PRESSING: begin
				if (lower && upper) begin
					phase_nxt = PH_PRESSED;
					ev.hit    = 1'b1;
				end
			end
			PH_PRESSED: begin
				if (lower && !upper) begin
					phase_nxt = PH_RELEASING;
					store     = 1'b1;
				end
			end
			PH_RELEASING: begin
				if (!lower && !upper) begin
					phase_nxt = PH_RELEASED;
					ev.hit    = 1'b1;
					ev.kind   = tcvt_pkg::KIND_RELEASE;
				end
			end
			default: begin
				phase_nxt = PH_RELEASED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RELEASED;
		end else if (step) begin
			phase_q <= phase_nxt;
		end
	end

	// start stamp is only read from the pressing/releasing phases, which always write it
	always_ff @(posedge clk) begin
		if (step && store) begin
			start_q <= now_tick;
		end
	end

endmodule

>>> design/tcvt_merge.sv
module tcvt_merge #(
	parameter int NUM_KEYS = tcvt_pkg::NUM_KEYS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  scan_valid,
	output logic                                  scan_ready,
	input  tcvt_pkg::lane_ev_t [NUM_KEYS-1:0]     lane_ev,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [tcvt_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	output logic                                  m_axis_tuser,
	output logic                                  m_axis_tlast
);

	logic [NUM_KEYS-1:0]           pending_q;
	logic [NUM_KEYS-1:0]           kind_q;
	logic [tcvt_pkg::TICK_W-1:0]   elapsed_q [NUM_KEYS];
	logic [NUM_KEYS-1:0]           low_bit;
	logic [NUM_KEYS-1:0]           rest;
	logic [NUM_KEYS-1:0]           hits;
	logic [tcvt_pkg::KEY_W-1:0]    sel_idx;
	logic [tcvt_pkg::TICK_W-1:0]   sel_elapsed;
	logic                          sel_kind;
	logic                          out_free;
	logic                          take;
	logic                          acc;
	logic [tcvt_pkg::KEY_W-1:0]    idx_q;
	logic [tcvt_pkg::TICK_W-1:0]   ela_q;
	logic                          knd_q;
	logic                          last_q;

	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			hits[k] = lane_ev[k].hit;
		end
	end

	// lowest pending key goes out first
	assign low_bit = pending_q & (~pending_q + NUM_KEYS'(1));
	assign rest    = pending_q & ~low_bit;

	always_comb begin
		sel_idx     = '0;
		sel_elapsed = '0;
		sel_kind    = 1'b0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (low_bit[k]) begin
				sel_idx     = sel_idx | tcvt_pkg::KEY_W'(k);
				sel_elapsed = sel_elapsed | elapsed_q[k];
				sel_kind    = sel_kind | kind_q[k];
			end
		end
	end

	assign out_free   = !m_axis_tvalid || m_axis_tready;
	assign take       = out_free && (pending_q != '0);
	assign scan_ready = (pending_q == '0) || (take && (rest == '0));
	assign acc        = scan_valid && scan_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (acc) begin
				pending_q <= hits;
			end else if (take) begin
				pending_q <= rest;
			end
			if (take) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				kind_q[k]    <= lane_ev[k].kind;
				elapsed_q[k] <= lane_ev[k].elapsed;
			end
		end
		if (take) begin
			idx_q  <= sel_idx;
			ela_q  <= sel_elapsed;
			knd_q  <= sel_kind;
			last_q <= (rest == '0);
		end
	end

	assign m_axis_tdata = {{tcvt_pkg::M_PAD_W{1'b0}}, ela_q, idx_q};
	assign m_axis_tuser = knd_q;
	assign m_axis_tlast = last_q;

`ifndef ASSERT_OFF
	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> $onehot(low_bit))
		else $error("merge picked other than one pending key");

	a_acc_drained: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (rest == '0))
		else $error("scan taken while events of previous scan still pending");

	a_last_matches: assert property (@(posedge clk) disable iff (!arst_n)
		take && !acc |=> m_axis_tvalid && (m_axis_tlast == (pending_q == '0)))
		else $error("tlast does not match draining of pending events");

	a_no_idle_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != '0) && !take |=> pending_q == $past(pending_q))
		else $error("pending events changed without a transfer");
`endif

endmodule

>>> design/two_contact_key_velocity_tracker.sv
// Key velocity tracker for a two-contact keyboard matrix. Each scan transfer
// carries the 64-bit contact word (key k: upper contact at bit FIRST_KEY_BIT+2k,
// lower at the next bit, 1 = closed) and an 8-bit tick stamp. One lane per key
// updates its phase (released, pressing, pressed, releasing) for the whole scan
// in the cycle it is accepted, and completed presses/releases are then sent out
// one per cycle in ascending key order while the output is ready, with elapsed
// = now minus start tick (mod 256) and tlast on the final event of the scan. The
// serial event drain is the limit: a scan with at most one event is taken each
// cycle the output is ready, and one with N events (up to NUM_KEYS) blocks the
// next until they drain. A scan with no completions produces no output transfer.
module two_contact_key_velocity_tracker #(
	parameter int NUM_KEYS      = tcvt_pkg::NUM_KEYS_DEF,
	parameter int FIRST_KEY_BIT = tcvt_pkg::FIRST_KEY_BIT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [63:0] contacts, [71:64] now_tick
	input  logic [tcvt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [4:0] key_index, [12:5] elapsed_ticks, [15:13] zero
	output logic [tcvt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// [0] event_kind
	output logic                              m_axis_tuser,
	output logic                              m_axis_tlast
);

	logic [tcvt_pkg::CONTACT_W-1:0]        contacts;
	logic [tcvt_pkg::TICK_W-1:0]           now_tick;
	logic                                  step;
	logic [NUM_KEYS-1:0]                   upper;
	logic [NUM_KEYS-1:0]                   lower;
	tcvt_pkg::lane_ev_t [NUM_KEYS-1:0]     lane_ev;

	assign contacts = s_axis_tdata[tcvt_pkg::CONTACT_W-1:0];
	assign now_tick = s_axis_tdata[tcvt_pkg::CONTACT_W +: tcvt_pkg::TICK_W];
	assign step     = s_axis_tvalid && s_axis_tready;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		localparam int UP_POS = FIRST_KEY_BIT + 2 * k;
		localparam int LO_POS = UP_POS + 1;

		if (UP_POS < tcvt_pkg::CONTACT_W) begin : g_up
			assign upper[k] = contacts[UP_POS];
		end else begin : g_up_open
			assign upper[k] = 1'b0;
		end

		if (LO_POS < tcvt_pkg::CONTACT_W) begin : g_lo
			assign lower[k] = contacts[LO_POS];
		end else begin : g_lo_open
			assign lower[k] = 1'b0;
		end

		tcvt_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (step),
			.upper    (upper[k]),
			.lower    (lower[k]),
			.now_tick (now_tick),
			.ev       (lane_ev[k])
		);
	end

	tcvt_merge #(
		.NUM_KEYS (NUM_KEYS)
	) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.scan_valid    (s_axis_tvalid),
		.scan_ready    (s_axis_tready),
		.lane_ev       (lane_ev),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
